@@ rtl/core/asfrs_pkg.sv @@
// Shared constants and types for the running-sum array block.
package asfrs_pkg;

	localparam int DEPTH      = 1024;
	localparam int VALUE_BITS = 30;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int COUNT_BITS = 11;
	localparam int SUM_BITS   = 40;
	localparam int PROD_BITS  = COUNT_BITS + VALUE_BITS;
	localparam int EPOCH_BITS = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1024);
	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(DEPTH);
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};
	localparam logic [EPOCH_BITS-1:0] EPOCH_STALE = '0;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_FILL = 1'b1;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] tag;
		logic [VALUE_BITS-1:0] val;
	} mem_word_t;

	typedef struct packed {
		logic                accept;
		logic                commit;
		logic                clear_wr;
		logic [IDX_BITS-1:0] clear_addr;
	} cmd_t;

	typedef struct packed {
		logic wrap;
	} sts_t;

endpackage

@@ rtl/core/asfrs_if.sv @@
// Valid/ready channel interfaces for operation words and result words.
interface asfrs_in_if import asfrs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [IDX_BITS-1:0]   index;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output operation, output index, output value, input ready);
	modport sink (input valid, input operation, input index, input value, output ready);
endinterface

interface asfrs_out_if import asfrs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SUM_BITS-1:0] total;
	logic                index_error;

	modport source (output valid, output total, output index_error, input ready);
	modport sink (input valid, input total, input index_error, output ready);
endinterface

@@ rtl/core/asfrs_ctrl.sv @@
// Controller state machine: clearing pass, accept and commit sequencing.
module asfrs_ctrl import asfrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	output logic res_valid,
	input  logic res_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t              state_q;
	state_t              state_nxt;
	logic [IDX_BITS-1:0] clr_cnt_q;
	logic                res_valid_q;
	logic                clr_last;

	assign clr_last = (clr_cnt_q == IDX_BITS'(DEPTH - 1));

	always_comb begin
		item_ready     = (state_q == ST_IDLE);
		cmd.accept     = item_valid && item_ready;
		cmd.commit     = (state_q == ST_EXEC) && (!res_valid_q || res_ready);
		cmd.clear_wr   = (state_q == ST_CLEAR);
		cmd.clear_addr = clr_cnt_q;
		res_valid      = res_valid_q;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.accept) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.commit) state_nxt = sts.wrap ? ST_CLEAR : ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.clear_wr) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/asfrs_dp.sv @@
// Datapath: entry memory, fill value, epoch, running sum and result register.
module asfrs_dp import asfrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_BITS-1:0] cfg_data,
	input  logic                  item_operation,
	input  logic [IDX_BITS-1:0]   item_index,
	input  logic [VALUE_BITS-1:0] item_value,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic [SUM_BITS-1:0]   total,
	output logic                  index_error
);

	mem_word_t             mem [DEPTH];
	mem_word_t             rd_q;
	logic                  op_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [COUNT_BITS-1:0] entry_count_q;
	logic [VALUE_BITS-1:0] fill_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [SUM_BITS-1:0]   total_q;
	logic                  err_q;

	logic [COUNT_BITS-1:0] cnt;
	logic                  err;
	logic [VALUE_BITS-1:0] cur;
	logic [PROD_BITS-1:0]  prod;
	logic [SUM_BITS-1:0]   new_sum;
	logic                  mem_we;
	logic [IDX_BITS-1:0]   mem_wa;
	mem_word_t             mem_wd;

	always_comb begin
		cnt      = (entry_count_q > COUNT_LIMIT) ? COUNT_LIMIT : entry_count_q;
		err      = (op_q == OP_SET) && (COUNT_BITS'(idx_q) >= cnt);
		// an entry tagged with an older epoch reads as the fill value
		cur      = (rd_q.tag == epoch_q) ? rd_q.val : fill_q;
		prod     = PROD_BITS'(cnt) * PROD_BITS'(val_q);
		if (op_q == OP_FILL) begin
			new_sum = prod[SUM_BITS-1:0];
		end else if (err) begin
			new_sum = sum_q;
		end else begin
			new_sum = sum_q - SUM_BITS'(cur) + SUM_BITS'(val_q);
		end
		sts.wrap = (op_q == OP_FILL) && (epoch_q == EPOCH_LAST);
		if (cmd.clear_wr) begin
			mem_we     = 1'b1;
			mem_wa     = cmd.clear_addr;
			mem_wd.tag = EPOCH_STALE;
			mem_wd.val = '0;
		end else begin
			mem_we     = cmd.commit && (op_q == OP_SET) && !err;
			mem_wa     = idx_q;
			mem_wd.tag = epoch_q;
			mem_wd.val = val_q;
		end
		total       = total_q;
		index_error = err_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.accept) begin
			rd_q  <= mem[item_index];
			op_q  <= item_operation;
			idx_q <= item_index;
			val_q <= item_value;
		end
		if (cmd.commit) begin
			total_q <= new_sum;
			err_q   <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= COUNT_RESET;
			fill_q        <= '0;
			sum_q         <= '0;
			epoch_q       <= EPOCH_FIRST;
		end else begin
			if (cfg_we) entry_count_q <= cfg_data;
			if (cmd.commit) begin
				sum_q <= new_sum;
				if (op_q == OP_FILL) begin
					fill_q  <= val_q;
					epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/core/array_set_fill_running_sum_top.sv @@
// Top level of the running-sum array with point set and global fill.
// The entry is read when a word is accepted; the word is committed once the result register is free.
// A new operation word is accepted only after the previous one has been committed.
// A waiting result word holds off only the commit of the next operation, not its acceptance.
// Reset: loads the count with 1024, clears sum and fill, restarts the epoch, then runs
// a clearing pass over every entry of the memory.
// The same pass follows every 255th fill, when the epoch tag wraps.
module array_set_fill_running_sum_top import asfrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_BITS-1:0] cfg_data,
	asfrs_in_if.sink              item,
	asfrs_out_if.source           result
);

	// Command and status between the sequencer and the datapath
	cmd_t cmd;
	sts_t sts;

	// The sequencer owns the handshakes: accept a word only when idle, commit
	// it once the result register is free, and run the memory clearing pass.
	asfrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the entry memory. Each entry carries an epoch tag, and
	// a fill advances the epoch, so every valid mark drops in one step. The
	// sum update and the fill product are worked out in the commit cycle.
	asfrs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.item_operation (item.operation),
		.item_index     (item.index),
		.item_value     (item.value),
		.cmd            (cmd),
		.sts            (sts),
		.total          (result.total),
		.index_error    (result.index_error)
	);

endmodule

@@ rtl/core/asfrs_chk.sv @@
// Port-level checker for the running-sum array top level, with its bind.
module asfrs_chk import asfrs_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SUM_BITS-1:0] out_total,
	input logic                out_error
);

	// one operation at a time: drop ready after every accepted word
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after an accepted word");

	// a fresh result word rises only for an operation that was accepted and then committed
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without matching operation");

	// hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_total) && $stable(out_error))
		else $error("stalled result word changed");

endmodule

bind array_set_fill_running_sum_top asfrs_chk u_asfrs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_total (result.total),
	.out_error (result.index_error)
);

@@ sim/array_set_fill_running_sum_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the running-sum array with point set and global fill.
module array_set_fill_running_sum_top_test;
	import asfrs_pkg::*;

	// Hold result words back this long to fill the block and stall its input.
	localparam int HOLD_CYCLES   = 400;
	// Idle time before a count write: covers the clearing pass after an epoch wrap.
	localparam int SETTLE_CYCLES = 1100;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LINES  = 40;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
	localparam logic [IDX_BITS-1:0]   INDEX_MAX = '1;

	typedef struct packed {
		logic                  operation;
		logic [IDX_BITS-1:0]   index;
		logic [VALUE_BITS-1:0] value;
	} op_word_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] total;
		logic                index_error;
	} sum_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [COUNT_BITS-1:0] cfg_data;

	asfrs_in_if  item_ch ();
	asfrs_out_if result_ch ();

	array_set_fill_running_sum_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	always #5 clk = ~clk;

	// Predicted copy of the array state and of the count register.
	logic [VALUE_BITS-1:0] entry_store [DEPTH];
	bit                    entry_marked [DEPTH];
	logic [VALUE_BITS-1:0] fill_level;
	logic [SUM_BITS-1:0]   running_total;
	logic [COUNT_BITS-1:0] count_reg;

	op_word_t  op_words [$];       // words waiting to be offered
	sum_word_t expected_sums [$];  // sums predicted for accepted words, oldest first

	// Sender and receiver pacing.
	bit       idling;
	int       burst_left;
	int       gap_left;
	logic [7:0] stall_bits;
	int       stall_step;
	int       hold_ask;
	int       hold_seen;
	int       hold_left;

	// Tallies.
	int cycle_count;
	int mismatches;
	int words_sent;
	int results_seen;
	int fills_seen;
	int flagged_seen;
	int settings_seen;

	op_word_t  taken_word;
	op_word_t  next_word;
	sum_word_t want;

	// Work out the sum that one accepted word must produce and queue it.
	task automatic predict_sum(input op_word_t w);
		logic [COUNT_BITS-1:0] lim;
		logic [VALUE_BITS-1:0] cur;
		sum_word_t             s;
		lim = (count_reg > COUNT_LIMIT) ? COUNT_LIMIT : count_reg;
		s.index_error = 1'b0;
		if (w.operation == OP_FILL) begin
			// Fill: new background value, sum from the count, drop every mark.
			fill_level    = w.value;
			running_total = SUM_BITS'(64'(lim) * 64'(w.value));
			foreach (entry_marked[i])
				entry_marked[i] = 1'b0;
			fills_seen++;
		end else if (w.index >= lim) begin
			// Out-of-range set: state untouched, flag it.
			s.index_error = 1'b1;
			flagged_seen++;
		end else begin
			cur = entry_marked[w.index] ? entry_store[w.index] : fill_level;
			running_total = running_total - cur + w.value;
			entry_store[w.index]  = w.value;
			entry_marked[w.index] = 1'b1;
		end
		s.total = running_total;
		expected_sums.push_back(s);
		words_sent++;
	endtask

	task automatic report_mismatch(input string what, input logic [SUM_BITS-1:0] got,
			input logic [SUM_BITS-1:0] wanted);
		if (mismatches < REPORT_LINES)
			$display("MISMATCH %s at result %0d: got %0d, expected %0d", what, results_seen,
				got, wanted);
		mismatches++;
	endtask

	task automatic queue_set(input logic [IDX_BITS-1:0] idx, input logic [VALUE_BITS-1:0] val);
		op_words.push_back('{OP_SET, idx, val});
	endtask

	task automatic queue_fill(input logic [IDX_BITS-1:0] idx, input logic [VALUE_BITS-1:0] val);
		op_words.push_back('{OP_FILL, idx, val});
	endtask

	// Mostly well-formed sets that revisit a few low entries, a good share of fills,
	// and some sets with an index drawn from the whole field.
	task automatic queue_random(input int n);
		op_word_t w;
		int       eff;
		int       pick;
		int       vpick;
		eff = (count_reg > COUNT_LIMIT) ? DEPTH : int'(count_reg);
		repeat (n) begin
			pick  = $urandom_range(99);
			vpick = $urandom_range(9);
			w.index = IDX_BITS'($urandom);
			if (vpick == 0)
				w.value = '0;
			else if (vpick == 1)
				w.value = VALUE_MAX;
			else
				w.value = VALUE_BITS'($urandom);
			if (pick < 30) begin
				w.operation = OP_FILL;
			end else begin
				w.operation = OP_SET;
				if (pick < 60 && eff > 0)
					w.index = IDX_BITS'($urandom_range((eff > 16) ? 15 : eff - 1));
				else if (pick < 88 && eff > 0)
					w.index = IDX_BITS'($urandom_range(eff - 1));
			end
			op_words.push_back(w);
		end
	endtask

	// Wait until nothing is queued, offered or outstanding.
	task automatic drain;
		while (op_words.size() != 0 || item_ch.valid || expected_sums.size() != 0)
			@(negedge clk);
	endtask

	// Write the count only with the block idle, and track it in the prediction.
	task automatic set_entry_count(input logic [COUNT_BITS-1:0] n);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg  = n;
		settings_seen++;
	endtask

	// Cycle limit: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("array_set_fill_running_sum_top verification failed");
			$finish;
		end
	end

	// Driver: predict on every accepted word, then offer the next one in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid     <= 1'b0;
			item_ch.operation <= OP_SET;
			item_ch.index     <= '0;
			item_ch.value     <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				taken_word.operation = item_ch.operation;
				taken_word.index     = item_ch.index;
				taken_word.value     = item_ch.value;
				predict_sum(taken_word);
			end
			// Hold an offered word until it is taken.
			if (!item_ch.valid || item_ch.ready) begin
				if (idling && gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (op_words.size() > 0) begin
					next_word = op_words.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.operation <= next_word.operation;
					item_ch.index     <= next_word.index;
					item_ch.value     <= next_word.value;
					if (idling) begin
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(11);
							gap_left   = $urandom_range(6);
						end
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result word against the oldest prediction, then pace ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_sums.size() == 0) begin
					report_mismatch("result word with nothing expected", result_ch.total, '0);
				end else begin
					want = expected_sums.pop_front();
					if (result_ch.total !== want.total)
						report_mismatch("total", result_ch.total, want.total);
					if (result_ch.index_error !== want.index_error)
						report_mismatch("index_error", SUM_BITS'(result_ch.index_error),
							SUM_BITS'(want.index_error));
				end
			end
			if (hold_seen != hold_ask) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// Long hold-off: the sender keeps offering words meanwhile.
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!idling) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ~stall_bits[0];
				stall_bits = {stall_bits[0], stall_bits[7:1]};
				stall_step++;
				if (stall_step == 8) begin
					stall_step = 0;
					stall_bits = 8'($urandom) & 8'($urandom);
				end
			end
		end
	end

	initial begin
		// Drive every input to a known value from time zero.
		item_ch.valid     = 1'b0;
		item_ch.operation = OP_SET;
		item_ch.index     = '0;
		item_ch.value     = '0;
		result_ch.ready   = 1'b0;
		cfg_we            = 1'b0;
		cfg_data          = COUNT_RESET;
		count_reg         = COUNT_RESET;
		fill_level        = '0;
		running_total     = '0;
		foreach (entry_marked[i])
			entry_marked[i] = 1'b0;
		idling        = 1'b1;
		burst_left    = 0;
		gap_left      = 0;
		stall_bits    = 8'h00;
		stall_step    = 0;
		hold_ask      = 0;
		hold_seen     = 0;
		hold_left     = 0;
		cycle_count   = 0;
		mismatches    = 0;
		words_sent    = 0;
		results_seen  = 0;
		fills_seen    = 0;
		flagged_seen  = 0;
		settings_seen = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Full count: extremes of index and value, overwrite of a marked entry,
		// a fill with its index field set, and sets that read the fill value.
		set_entry_count(COUNT_BITS'(1024));
		queue_set('0, '0);
		queue_set(INDEX_MAX, VALUE_MAX);
		queue_set(INDEX_MAX, VALUE_BITS'(1));
		queue_set(IDX_BITS'(10'h155), VALUE_BITS'(30'h2AAAAAAA));
		queue_set(IDX_BITS'(10'h2AA), VALUE_BITS'(30'h15555555));
		queue_fill(INDEX_MAX, VALUE_MAX);
		queue_set(INDEX_MAX, '0);
		queue_set(INDEX_MAX, VALUE_BITS'(5));
		queue_fill('0, '0);
		queue_set(IDX_BITS'(512), VALUE_MAX);
		// Hold the receiver off while a long random run is offered.
		hold_ask++;
		queue_random(250);

		// Count zero: every set is flagged and a fill gives a zero sum.
		set_entry_count('0);
		queue_set('0, VALUE_BITS'(7));
		queue_set(INDEX_MAX, VALUE_MAX);
		queue_fill('0, VALUE_MAX);
		queue_random(30);

		// Count one: only entry zero is in range.
		set_entry_count(COUNT_BITS'(1));
		queue_set('0, VALUE_MAX);
		queue_set(IDX_BITS'(1), VALUE_BITS'(3));
		queue_fill('0, VALUE_BITS'(9));
		queue_set('0, VALUE_BITS'(2));
		queue_set(INDEX_MAX, VALUE_BITS'(1));
		queue_random(40);

		// Count above the depth saturates; run this one with no idling at all.
		set_entry_count('1);
		idling = 1'b0;
		queue_fill('0, VALUE_MAX);
		queue_set(INDEX_MAX, '0);
		queue_set('0, VALUE_MAX);
		queue_random(150);

		set_entry_count(COUNT_BITS'(1025));
		idling = 1'b1;
		queue_random(100);

		// Random counts inside the depth; the sum carries over unchanged.
		for (int p = 0; p < 3; p++) begin
			set_entry_count(COUNT_BITS'($urandom_range(1023, 2)));
			if (p == 1)
				hold_ask++;
			queue_random(100);
		end

		set_entry_count(COUNT_BITS'(1024));
		queue_random(200);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result words from %0d operation words: %0d fills, %0d flagged sets.",
			results_seen, words_sent, fills_seen, flagged_seen);
		$display("Count register written %0d times, covering 0, 1, 1024, 1025 and 2047.",
			settings_seen);
		if (mismatches == 0) begin
			$display("array_set_fill_running_sum_top verification clean");
		end else begin
			$display("array_set_fill_running_sum_top verification failed");
		end
		$finish;
	end

endmodule
